// ===== hdl/gllw_pkg.sv =====
package gllw_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_ORDER = 4;
	localparam int IDX_W = 2;
	localparam int COORD_W = 17;
	localparam int WGT_W = 18;
	// One-dimensional weights stay within about [-2, 2] in Q.16.
	localparam int W1_W = 20;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 3;
	localparam int ORDER_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MONOTONE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'd1;

	localparam logic signed [WGT_W-1:0] W_MAX = 18'sd131071;
	localparam logic signed [WGT_W-1:0] W_MIN = -18'sd131072;

	// Constants (p + q*sqrt5)/2^d rounded to Q.16.
	localparam logic signed [W1_W-1:0] K_ONE = 20'sd65536;
	localparam logic signed [W1_W-1:0] K_F58 = 20'sd40960;
	localparam logic signed [W1_W-1:0] K_F18 = 20'sd8192;
	localparam logic signed [W1_W-1:0] K_R58 = 20'sd91589;
	localparam logic signed [W1_W-1:0] K_A1 = 20'sd32768;
	localparam logic signed [W1_W-1:0] K_B1 = -20'sd109907;
	localparam logic signed [W1_W-1:0] K_D1 = 20'sd183179;
	localparam logic signed [W1_W-1:0] K_A0 = 20'sd13255;
	localparam logic signed [W1_W-1:0] K_B0 = 20'sd29639;
	localparam logic signed [W1_W-1:0] K_C0 = -20'sd66275;
	localparam logic signed [W1_W-1:0] K_D0 = -20'sd148195;

	typedef logic signed [W1_W-1:0] w1_t;
	typedef w1_t [MAX_ORDER-1:0] wvec_t;

	// One queued word: both weight vectors and the order in use.
	typedef struct packed {
		wvec_t wa;
		wvec_t wb;
		logic [IDX_W-1:0] last_idx;
	} job_t;

	// Rounded Q.16 product (round half up).
	function automatic w1_t qmul(input w1_t a, input w1_t b);
		logic signed [2*W1_W-1:0] p;
		begin
			p = a * b + (2*W1_W)'(1 <<< (FRAC_BITS - 1));
			qmul = w1_t'(p >>> FRAC_BITS);
		end
	endfunction

endpackage

// ===== hdl/gllw_if.sv =====
interface gllw_in_if;
	logic valid;
	logic ready;
	logic [16:0] alpha;
	logic [16:0] beta;
	modport source(output valid, alpha, beta, input ready);
	modport sink(input valid, alpha, beta, output ready);
endinterface

interface gllw_out_if;
	logic valid;
	logic ready;
	logic [1:0] alpha_index;
	logic [1:0] beta_index;
	logic signed [17:0] weight;
	logic last;
	modport source(output valid, alpha_index, beta_index, weight, last, input ready);
	modport sink(input valid, alpha_index, beta_index, weight, last, output ready);
endinterface

// ===== hdl/gllw_front.sv =====
// Front part: maps both coordinates and evaluates the 1-D weights in a
// four-stage pipeline, one multiply level per stage.
module gllw_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [gllw_pkg::COORD_W-1:0] alpha,
	input  logic [gllw_pkg::COORD_W-1:0] beta,
	input  logic mono,
	input  logic [gllw_pkg::ORDER_W-1:0] order,
	input  logic adv,
	output logic job_valid,
	output gllw_pkg::job_t job
);
	import gllw_pkg::*;

	// Per direction stage data: x, region flags, Horner accumulators.
	typedef struct packed {
		w1_t x;
		logic neg;
		logic mid;
		w1_t x2;
		wvec_t acc;
	} dir_t;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [1:0] n_s1, n_s2, n_s3, n_s4;
	logic mono_s1, mono_s2, mono_s3;
	dir_t a_s1, a_s2, a_s3, b_s1, b_s2, b_s3;
	wvec_t wa_s4, wb_s4;
	logic [1:0] n_c;

	assign in_ready = adv;

	// Clamp order: code 0 is order 2, code 2 is order 4.
	always_comb begin
		if (order <= 3'd2) n_c = 2'd0;
		else if (order == 3'd3) n_c = 2'd1;
		else n_c = 2'd2;
	end

	function automatic dir_t map_coord(input logic [COORD_W-1:0] c);
		logic [COORD_W-1:0] cs;
		logic signed [COORD_W+1:0] x16;
		logic [35:0] sq;
		dir_t d;
		begin
			cs = (c > 17'd65536) ? 17'd65536 : c;
			x16 = $signed({1'b0, cs, 1'b0}) - 19'sd65536;
			sq = 36'(x16 * x16);
			d = '0;
			d.x = w1_t'(x16);
			d.neg = x16 < 0;
			d.mid = (sq * 36'd5) <= 36'h1_0000_0000;
			map_coord = d;
		end
	endfunction

	// Stage 2: x^2 and first Horner step.
	function automatic dir_t st2(input dir_t d, input logic mo);
		dir_t r;
		begin
			r = d;
			r.x2 = qmul(d.x, d.x);
			r.acc[0] = qmul(-K_F58, d.x) + K_F58;
			r.acc[1] = qmul(K_R58, d.x) - K_F58;
			r.acc[2] = qmul(-K_R58, d.x) - K_F58;
			r.acc[3] = qmul(K_F58, d.x) + K_F58;
			if (mo) begin
				r.acc[1] = qmul(K_D1, d.x);
				r.acc[0] = qmul(K_D0, d.x) + K_C0;
				r.acc[3] = qmul(-K_D0, d.x) + K_C0;
			end
			st2 = r;
		end
	endfunction

	function automatic dir_t st3(input dir_t d, input logic mo);
		dir_t r;
		begin
			r = d;
			r.acc[0] = qmul(d.acc[0], d.x) + (mo ? K_B0 : K_F18);
			r.acc[1] = qmul(d.acc[1], d.x) + (mo ? K_B1 : -K_R58);
			r.acc[2] = qmul(d.acc[2], d.x) + K_R58;
			r.acc[3] = qmul(d.acc[3], d.x) + (mo ? -K_B0 : -K_F18);
			st3 = r;
		end
	endfunction

	function automatic wvec_t st4(input dir_t d, input logic [1:0] n, input logic mo);
		wvec_t h, w;
		begin
			h[0] = qmul(d.acc[0], d.x) + (mo ? K_A0 : -K_F18);
			h[1] = qmul(d.acc[1], d.x) + (mo ? K_A1 : K_F58);
			h[2] = qmul(d.acc[2], d.x) + K_F58;
			h[3] = qmul(d.acc[3], d.x) + (mo ? K_A0 : -K_F18);
			w = '0;
			case (n)
				2'd0: begin
					w[0] = w1_t'((K_ONE - d.x + 20'sd1) >>> 1);
					w[1] = w1_t'((K_ONE + d.x + 20'sd1) >>> 1);
				end
				2'd1: begin
					if (!mo) begin
						w[0] = w1_t'((d.x2 - d.x + 20'sd1) >>> 1);
						w[1] = K_ONE - d.x2;
						w[2] = w1_t'((d.x2 + d.x + 20'sd1) >>> 1);
					end else if (d.neg) begin
						w[0] = d.x2;
						w[1] = K_ONE - d.x2;
					end else begin
						w[1] = K_ONE - d.x2;
						w[2] = d.x2;
					end
				end
				default: begin
					if (!mo) begin
						w = h;
					end else if (d.mid) begin
						w[1] = h[1];
						w[2] = K_ONE - h[1];
					end else if (d.neg) begin
						w[0] = h[0];
						w[1] = K_ONE - h[0];
					end else begin
						w[3] = h[3];
						w[2] = K_ONE - h[3];
					end
				end
			endcase
			st4 = w;
		end
	endfunction

	// Control of the pipeline: all stages move together on adv.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1 <= n_c;
			mono_s1 <= mono;
			a_s1 <= map_coord(alpha);
			b_s1 <= map_coord(beta);
			n_s2 <= n_s1;
			mono_s2 <= mono_s1;
			a_s2 <= st2(a_s1, mono_s1);
			b_s2 <= st2(b_s1, mono_s1);
			n_s3 <= n_s2;
			mono_s3 <= mono_s2;
			a_s3 <= st3(a_s2, mono_s2);
			b_s3 <= st3(b_s2, mono_s2);
			n_s4 <= n_s3;
			wa_s4 <= st4(a_s3, n_s3, mono_s3);
			wb_s4 <= st4(b_s3, n_s3, mono_s3);
		end
	end

	assign job_valid = v_s4;
	assign job.wa = wa_s4;
	assign job.wb = wb_s4;
	assign job.last_idx = n_s4 + 2'd1;

	// The order code in the last stage is always a clamped one.
	assert property (@(posedge clk) disable iff (!arst_n) v_s4 |-> n_s4 != 2'd3)
		else $error("bad order code");
	assert property (@(posedge clk) disable iff (!arst_n) !adv |=> $stable(v_s4))
		else $error("pipeline moved while held");
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && in_valid |=> v_s1)
		else $error("accepted word lost");

endmodule

// ===== hdl/gllw_queue.sv =====
// Two-entry queue between the weight pipeline and the emitter.
module gllw_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  gllw_pkg::job_t wdata,
	output logic full,
	output logic almost_full,
	input  logic rd,
	output logic empty,
	output gllw_pkg::job_t rdata
);
	import gllw_pkg::*;

	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign almost_full = cnt_q != 2'd0;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	assert property (@(posedge clk) disable iff (!arst_n) wr |-> !full || rd)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) rd |-> !empty)
		else $error("queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("bad fill count");

endmodule

// ===== hdl/gllw_back.sv =====
// Back part: walks i outer, j inner over one queued word, through a multiply
// register and a two-entry output skid, one product a cycle while it has room.
module gllw_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_empty,
	input  gllw_pkg::job_t job,
	output logic job_pop,
	gllw_out_if.source out
);
	import gllw_pkg::*;

	logic [IDX_W-1:0] i_q, j_q;
	logic v_s1;
	logic [IDX_W-1:0] i_s1, j_s1;
	logic last_s1;
	logic signed [2*W1_W-1:0] p_s1;
	logic signed [2*W1_W-1:0] r;
	logic signed [WGT_W-1:0] w_sat;
	logic issue, is_last;
	// Output skid: two slots.
	logic [1:0] ocnt_q;
	logic owp_q, orp_q;
	logic [IDX_W-1:0] oi_q [2];
	logic [IDX_W-1:0] oj_q [2];
	logic signed [WGT_W-1:0] ow_q [2];
	logic ol_q [2];
	logic opop;

	assign opop = out.valid && out.ready;
	// Issue only if the skid has room for what is in flight.
	assign issue = !job_empty && (ocnt_q == 2'd0 || (ocnt_q == 2'd1 && !v_s1) || opop && !v_s1
		&& ocnt_q != 2'd2 || (ocnt_q == 2'd1 && opop));
	assign is_last = i_q == job.last_idx && j_q == job.last_idx;
	assign job_pop = issue && is_last;

	// Index counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (issue) begin
				if (j_q == job.last_idx) begin
					j_q <= '0;
					i_q <= is_last ? '0 : i_q + 2'd1;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= job.wa[i_q] * job.wb[j_q];
		i_s1 <= i_q;
		j_s1 <= j_q;
		last_s1 <= is_last;
	end

	// Rounding and saturation of the product.
	always_comb begin
		r = (p_s1 + (2*W1_W)'(1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (r > W_MAX) w_sat = W_MAX;
		else if (r < W_MIN) w_sat = W_MIN;
		else w_sat = WGT_W'(r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= 2'd0;
			owp_q <= 1'b0;
			orp_q <= 1'b0;
		end else begin
			if (v_s1) owp_q <= ~owp_q;
			if (opop) orp_q <= ~orp_q;
			ocnt_q <= ocnt_q + {1'b0, v_s1} - {1'b0, opop};
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			oi_q[owp_q] <= i_s1;
			oj_q[owp_q] <= j_s1;
			ow_q[owp_q] <= w_sat;
			ol_q[owp_q] <= last_s1;
		end
	end

	assign out.valid = ocnt_q != 2'd0;
	assign out.alpha_index = oi_q[orp_q];
	assign out.beta_index = oj_q[orp_q];
	assign out.weight = ow_q[orp_q];
	assign out.last = ol_q[orp_q];

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ocnt_q != 2'd2 || opop)
		else $error("output skid overflow");
	assert property (@(posedge clk) disable iff (!arst_n) ocnt_q != 2'd3)
		else $error("bad skid count");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> i_q == '0 && j_q == '0)
		else $error("counters not rewound");

endmodule

// ===== hdl/gll_interpolation_weights_2d.sv =====
// Channel  Dir  Word
// in       in   alpha[16:0], beta[16:0]
// out      out  alpha_index[1:0], beta_index[1:0], weight[17:0], last
// cfg      in   cfg_we, cfg_idx, cfg_data (monotone_mode, order)
//
// A sample point passes a four-stage weight pipeline, then waits in a
// two-entry queue. The emitter gives one weight per cycle unless out stalls,
// order*order weights per point (4, 9 or 16); it sets the sustained rate.
// Its weights pass a multiply register and a two-entry output skid.
// Reset clears all control state; the registers return to Lagrange, order 4.
// Stalls on out back up into the queue, then hold the weight pipeline.
module gll_interpolation_weights_2d (
	input  logic clk,
	input  logic arst_n,
	gllw_in_if.sink in,
	gllw_out_if.source out,
	input  logic cfg_we,
	input  logic [gllw_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [gllw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gllw_pkg::*;

	logic mono_q;
	logic [ORDER_W-1:0] order_q;
	logic job_valid, q_full, q_af, q_empty, q_pop, adv;
	job_t job_w, job_r;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q <= 1'b0;
			order_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MONOTONE: mono_q <= cfg_data[0];
				REG_ORDER: order_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves unless its finished word cannot enter the queue.
	assign adv = !(job_valid && q_full);

	gllw_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready),
		.alpha(in.alpha), .beta(in.beta),
		.mono(mono_q), .order(order_q),
		.adv(adv), .job_valid(job_valid), .job(job_w)
	);

	gllw_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr(job_valid && !q_full), .wdata(job_w),
		.full(q_full), .almost_full(q_af),
		.rd(q_pop), .empty(q_empty), .rdata(job_r)
	);

	gllw_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_empty(q_empty), .job(job_r), .job_pop(q_pop),
		.out(out)
	);

	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> q_af)
		else $error("queue flags disagree");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		in.valid && in.ready |-> adv)
		else $error("accepted while held");

endmodule

// ===== verif/testbench.sv =====
module testbench;
	import gllw_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_MONOTONE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	gllw_in_if in_ch();
	gllw_out_if out_ch();

	gll_interpolation_weights_2d uut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		logic [1:0] ai;
		logic [1:0] bi;
		logic signed [WGT_W-1:0] w;
		logic last;
	} weight_word_t;

	// Directed stimulus: settings, the point, and an optional typed first weight.
	typedef struct {
		bit mono;
		logic [ORDER_W-1:0] order;
		logic [COORD_W-1:0] alpha;
		logic [COORD_W-1:0] beta;
		bit has_first;
		longint first_w;
	} point_row_t;

	weight_word_t pending_weights[$];
	bit shadow_mono = 1'b0;
	logic [ORDER_W-1:0] shadow_order = 3'd4;
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// Round half up on a right shift; >>> on longint floors.
	function automatic longint round_shift(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint qprod(input longint a, input longint b);
		return round_shift(a * b, FRAC_BITS);
	endfunction

	function automatic longint cubic(input longint c3, input longint c2, input longint c1,
			input longint c0, input longint x);
		return qprod(qprod(qprod(c3, x) + c2, x) + c1, x) + c0;
	endfunction

	// One-dimensional GLL weights for one coordinate.
	function automatic void node_weights(input logic [COORD_W-1:0] c, input int n,
			input bit mono, output longint w[4]);
		longint one, x, x2, cc;
		one = 64'sd1 <<< FRAC_BITS;
		cc = (c > 17'd65536) ? 65536 : longint'(c);
		x = 2 * cc - 65536;
		x2 = qprod(x, x);
		for (int k = 0; k < 4; k++) w[k] = 0;
		if (n == 2) begin
			w[0] = round_shift(one - x, 1);
			w[1] = round_shift(one + x, 1);
		end else if (n == 3) begin
			if (!mono) begin
				w[0] = round_shift(x2 - x, 1);
				w[1] = one - x2;
				w[2] = round_shift(x2 + x, 1);
			end else if (x < 0) begin
				w[0] = x2;
				w[1] = one - x2;
			end else begin
				w[1] = one - x2;
				w[2] = x2;
			end
		end else if (!mono) begin
			w[0] = cubic(-K_F58, K_F58, K_F18, -K_F18, x);
			w[1] = cubic(K_R58, -K_F58, -K_R58, K_F58, x);
			w[2] = cubic(-K_R58, -K_F58, K_R58, K_F58, x);
			w[3] = cubic(K_F58, K_F58, -K_F18, -K_F18, x);
		end else if (5 * x * x <= (64'sd1 <<< 32)) begin
			// Central interval between the two inner nodes.
			w[1] = cubic(K_D1, 0, K_B1, K_A1, x);
			w[2] = one - w[1];
		end else if (x < 0) begin
			w[0] = cubic(K_D0, K_C0, K_B0, K_A0, x);
			w[1] = one - w[0];
		end else begin
			w[3] = cubic(-K_D0, K_C0, -K_B0, K_A0, x);
			w[2] = one - w[3];
		end
	endfunction

	// Queue every tensor-product weight of one accepted point.
	task automatic predict_point(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
		longint wa[4], wb[4];
		longint p;
		int n;
		weight_word_t e;
		n = (shadow_order < 2) ? 2 : (shadow_order > MAX_ORDER) ? MAX_ORDER : int'(shadow_order);
		node_weights(a, n, shadow_mono, wa);
		node_weights(b, n, shadow_mono, wb);
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				p = round_shift(wa[i] * wb[j], 2 * FRAC_BITS - 16);
				if (p > W_MAX) p = W_MAX;
				if (p < W_MIN) p = W_MIN;
				e.ai = i[1:0];
				e.bi = j[1:0];
				e.w = p[WGT_W-1:0];
				e.last = (i == n - 1) && (j == n - 1);
				pending_weights.push_back(e);
			end
		end
	endtask

	// Cycle count and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Accepted points feed the predictor.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) predict_point(in_ch.alpha, in_ch.beta);
	end

	// Each accepted weight word is compared with the oldest expectation.
	always @(posedge clk) begin
		weight_word_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_weights.size() == 0) begin
				report_mismatch("unexpected word, weight", out_ch.weight, 0);
			end else begin
				e = pending_weights.pop_front();
				if (out_ch.alpha_index !== e.ai) report_mismatch("alpha_index", out_ch.alpha_index, e.ai);
				if (out_ch.beta_index !== e.bi) report_mismatch("beta_index", out_ch.beta_index, e.bi);
				if (out_ch.weight !== e.w) report_mismatch("weight", out_ch.weight, e.w);
				if (out_ch.last !== e.last) report_mismatch("last", out_ch.last, e.last);
			end
		end
	end

	// Receiver stalls at random.
	always @(negedge clk) begin
		out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic wait_drained();
		while (pending_weights.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(posedge clk);
		if (idx == REG_MONOTONE) shadow_mono = val[0];
		else shadow_order = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_mode(input bit mono, input logic [ORDER_W-1:0] order);
		wait_drained();
		write_reg(REG_MONOTONE, {2'b00, mono});
		write_reg(REG_ORDER, order);
	endtask

	// Offer one point after a random gap and hold it until accepted.
	task automatic send_point(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.alpha = a;
		in_ch.beta = b;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] random_coord();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return COORD_W'($urandom_range(131071, 65537));
			3: return COORD_W'($urandom_range(47430, 47415));
			4: return COORD_W'($urandom_range(18120, 18105));
			5: return COORD_W'($urandom_range(32770, 32766));
			default: return COORD_W'($urandom_range(65536));
		endcase
	endfunction

	point_row_t rows[] = '{
		'{0, 3'd2, 17'd0, 17'd0, 1, 65536},
		'{0, 3'd2, 17'd65536, 17'd65536, 1, 0},
		'{0, 3'd2, 17'd131071, 17'd0, 1, 0},
		'{0, 3'd2, 17'd32768, 17'd16384, 0, 0},
		'{0, 3'd3, 17'd0, 17'd0, 1, 65536},
		'{0, 3'd3, 17'd32768, 17'd65536, 0, 0},
		'{0, 3'd4, 17'd0, 17'd65536, 0, 0},
		'{0, 3'd4, 17'd40000, 17'd65537, 0, 0},
		'{1, 3'd2, 17'd0, 17'd0, 1, 65536},
		'{1, 3'd2, 17'd12345, 17'd54321, 0, 0},
		'{1, 3'd3, 17'd32767, 17'd32768, 0, 0},
		'{1, 3'd3, 17'd0, 17'd65536, 0, 0},
		'{1, 3'd4, 17'd47422, 17'd47423, 0, 0},
		'{1, 3'd4, 17'd18114, 17'd18113, 0, 0},
		'{1, 3'd4, 17'd0, 17'd131071, 0, 0},
		'{1, 3'd4, 17'd32768, 17'd32768, 0, 0},
		'{0, 3'd0, 17'd0, 17'd0, 1, 65536},
		'{1, 3'd1, 17'd20000, 17'd60000, 0, 0},
		'{0, 3'd5, 17'd10000, 17'd30000, 0, 0},
		'{1, 3'd7, 17'd65536, 17'd0, 0, 0}
	};

	initial begin
		logic [ORDER_W-1:0] order_pick;
		in_ch.valid = 1'b0;
		in_ch.alpha = '0;
		in_ch.beta = '0;
		out_ch.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part; a typed first weight is checked against the prediction.
		foreach (rows[r]) begin
			if (rows[r].mono != shadow_mono || rows[r].order != shadow_order)
				set_mode(rows[r].mono, rows[r].order);
			send_point(rows[r].alpha, rows[r].beta);
			if (rows[r].has_first && pending_weights.size() != 0 &&
					longint'(pending_weights[pending_weights.size() -
					((shadow_order < 2) ? 4 : (shadow_order == 3) ? 9 :
					(shadow_order == 2) ? 4 : 16)].w) != rows[r].first_w)
				report_mismatch("first weight of directed point", 0, rows[r].first_w);
		end

		// Random part in four idling phases, settings changed when drained.
		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < 120; k++) begin
				if (k % 30 == 0) begin
					order_pick = ($urandom_range(4) == 0) ? ORDER_W'($urandom_range(7))
						: ORDER_W'($urandom_range(4, 2));
					set_mode(1'($urandom_range(1)), order_pick);
				end
				// Idling of this phase, except for a short burst without idling on either side.
				if (k >= 60 && k < 70) begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end else begin
					send_idle_pct = (ph == 1) ? 87 : (ph == 3) ? 13 : 0;
					recv_stall_pct = (ph == 2) ? 87 : (ph == 3) ? 13 : 0;
				end
				if (k == 90) wait_drained();
				send_point(random_coord(), random_coord());
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending_weights.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/gllw_pkg.sv
hdl/gllw_if.sv
hdl/gllw_front.sv
hdl/gllw_queue.sv
hdl/gllw_back.sv
hdl/gll_interpolation_weights_2d.sv
verif/testbench.sv
